// File: design/nfba_pkg.sv
package nfba_pkg;

  // fixed field widths
  localparam int unsigned MODE_W  = 1;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned LIM_W   = 11;
  localparam int unsigned STAT_W  = 2;

  // bitmap word geometry
  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned OFF_W     = 6;

  // configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 32;
  localparam logic [0:0] REG_LIMIT = 1'b0;
  localparam logic [LIM_W-1:0] LIMIT_RESET = 11'd1024;

  // request kinds
  localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_USED = 2'd3;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot_to_free;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [SLOT_W-1:0]  granted_slot;
    logic [COUNT_W-1:0] occupied_count;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              advance;
    logic              do_alloc;
    logic              do_free;
    logic              report;
    logic [STAT_W-1:0] res_status;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic pool_full;
    logic out_of_range;
    logic target_used;
    logic found;
    logic last_word;
  } dp_sts_t;

endpackage

// File: design/next_fit_bitmap_slot_allocator.sv
// Next-fit slot allocator. Pulse start with a request while busy is low; one
// result beat follows on out_res with out_strobe high for exactly one cycle,
// and it cannot be held off, so the receiver must take it when it appears.
// A free, a pool-full answer and an out-of-range answer are decided in the
// first evaluation state after start. An allocate reads one 64-bit bitmap
// word per cycle through the single read port and picks the first free bit
// with a priority encoder. A new request may be started in the cycle its
// predecessor's result beat is shown. The user must write slots_in_use_limit
// (byte address 0) only while busy is low and no result is pending; the
// block itself does not enforce this.
module next_fit_bitmap_slot_allocator #(
  parameter int unsigned NUM_SLOTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // request channel
  input  logic                          start,
  output logic                          busy,
  input  nfba_pkg::req_t                in_req,
  // result channel
  output logic                          out_strobe,
  output nfba_pkg::res_t                out_res,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nfba_pkg::CFG_AW-1:0]   paddr,
  input  logic [nfba_pkg::CFG_DW-1:0]   pwdata,
  output logic [nfba_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready
);
  import nfba_pkg::*;

  logic [LIM_W-1:0] limit_r;
  logic             reg_hit;
  dp_cmd_t          cmd;
  dp_sts_t          sts;

  // register decode
  assign pready  = 1'b1;
  assign reg_hit = (paddr[CFG_AW-1:2] == REG_LIMIT);
  assign prdata  = reg_hit ? CFG_DW'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      limit_r <= pwdata[LIM_W-1:0];
    end
  end

  nfba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  nfba_dpath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .req        (in_req),
    .limit_reg  (limit_r),
    .res_strobe (out_strobe),
    .res        (out_res)
  );

endmodule

// File: design/nfba_ctrl.sv
module nfba_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  nfba_pkg::dp_sts_t sts,
  output nfba_pkg::dp_cmd_t cmd
);
  import nfba_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EVAL = 1'b1;

  logic state_r;
  logic state_nxt;

  assign busy = (state_r == S_EVAL);

  // decide the outcome of each evaluated word
  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.res_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt  = S_IDLE;
        cmd.report = 1'b1;
        if (sts.is_free) begin
          if (sts.out_of_range) begin
            cmd.res_status = ST_RANGE;
          end else if (!sts.target_used) begin
            cmd.res_status = ST_NOT_USED;
          end else begin
            cmd.do_free = 1'b1;
          end
        end else if (sts.pool_full) begin
          cmd.res_status = ST_FULL;
        end else if (sts.found) begin
          cmd.do_alloc = 1'b1;
        end else if (sts.last_word) begin
          cmd.res_status = ST_FULL;
        end else begin
          // nothing free in this word, move to the next one
          cmd.report  = 1'b0;
          cmd.advance = 1'b1;
          state_nxt   = S_EVAL;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/nfba_dpath.sv
module nfba_dpath #(
  parameter int unsigned NUM_SLOTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nfba_pkg::dp_cmd_t             cmd,
  output nfba_pkg::dp_sts_t             sts,
  input  nfba_pkg::req_t                req,
  input  logic [nfba_pkg::LIM_W-1:0]    limit_reg,
  output logic                          res_strobe,
  output nfba_pkg::res_t                res
);
  import nfba_pkg::*;

  localparam int unsigned MAP_WORDS = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WAW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned XW = (LIM_W > OFF_W + WAW) ? LIM_W : OFF_W + WAW;
  localparam int unsigned LIM_CAP = (NUM_SLOTS < 2047) ? NUM_SLOTS : 2047;

  // bitmap storage, valid bit per word stands in for the reset clear
  logic [WORD_BITS-1:0] bitmap_mem [MAP_WORDS];
  logic                 word_vld_r [MAP_WORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic                 rd_vld_r;
  logic [WAW-1:0]       rd_addr;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;

  // request and search state
  logic [MODE_W-1:0]  mode_r;
  logic [SLOT_W-1:0]  target_r;
  logic [WAW-1:0]     cursor_r, cursor_nxt;
  logic               wrapped_r, wrapped_nxt;
  logic [WAW-1:0]     ws_r;
  logic [OFF_W-1:0]   soff_r;
  logic [SLOT_W-1:0]  head_r, head_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic [LIM_W-1:0]     limit;
  logic [XW-1:0]        lim_ext, lim_m1, head_ext, start_idx, tgt_ext, req_ext;
  logic [WAW-1:0]       last_w;
  logic [WORD_BITS-1:0] rd_word, lim_mask, pass_mask, cand, bit_sel;
  logic [OFF_W-1:0]     hit_off;
  logic [XW-1:0]        hit_idx, hit_idx1;

  function automatic logic [OFF_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
    logic [OFF_W-1:0] p;
    p = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        p = OFF_W'(i);
      end
    end
    return p;
  endfunction

  // effective limit, clamped to the built slot count
  assign limit    = (32'(limit_reg) > LIM_CAP) ? LIM_W'(LIM_CAP) : limit_reg;
  assign lim_ext  = XW'(limit);
  assign lim_m1   = lim_ext - XW'(1);
  assign last_w   = lim_m1[OFF_W +: WAW];
  assign head_ext = XW'(head_r);
  assign start_idx = (head_ext < lim_ext) ? head_ext : '0;
  assign tgt_ext  = XW'(target_r);
  assign req_ext  = XW'(req.slot_to_free);

  // word under evaluation
  assign rd_word = rd_vld_r ? rd_data_r : '0;

  // bits of this word that belong to the current pass
  always_comb begin
    lim_mask = '1;
    if (cursor_r == last_w) begin
      lim_mask = {WORD_BITS{1'b1}} >> (OFF_W'(WORD_BITS - 1) - lim_m1[OFF_W-1:0]);
    end
    pass_mask = '1;
    if (cursor_r == ws_r) begin
      if (wrapped_r) begin
        pass_mask = ~({WORD_BITS{1'b1}} << soff_r);
      end else begin
        pass_mask = {WORD_BITS{1'b1}} << soff_r;
      end
    end
  end

  assign cand     = ~rd_word & lim_mask & pass_mask;
  assign hit_off  = lowest_set(cand);
  assign hit_idx  = XW'({cursor_r, hit_off});
  assign hit_idx1 = hit_idx + XW'(1);

  // status to the controller
  assign sts.is_free      = (mode_r == MODE_FREE);
  assign sts.pool_full    = (count_r >= COUNT_W'(limit));
  assign sts.out_of_range = (tgt_ext >= lim_ext);
  assign sts.target_used  = rd_word[target_r[OFF_W-1:0]];
  assign sts.found        = |cand;
  assign sts.last_word    = wrapped_r && (cursor_r == ws_r);

  // cursor walk and memory read address
  always_comb begin
    cursor_nxt  = cursor_r;
    wrapped_nxt = wrapped_r;
    if (cmd.load) begin
      wrapped_nxt = 1'b0;
      if (req.mode == MODE_FREE) begin
        cursor_nxt = req_ext[OFF_W +: WAW];
      end else begin
        cursor_nxt = start_idx[OFF_W +: WAW];
      end
    end else if (cmd.advance) begin
      if (!wrapped_r && (cursor_r == last_w)) begin
        cursor_nxt  = '0;
        wrapped_nxt = 1'b1;
      end else begin
        cursor_nxt = cursor_r + WAW'(1);
      end
    end
  end

  assign rd_addr = cursor_nxt;

  // bitmap update, head and count
  always_comb begin
    bit_sel   = '0;
    wr_en     = 1'b0;
    wr_data   = rd_word;
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.do_alloc) begin
      bit_sel   = {{(WORD_BITS-1){1'b0}}, 1'b1} << hit_off;
      wr_en     = 1'b1;
      wr_data   = rd_word | bit_sel;
      count_nxt = count_r + COUNT_W'(1);
      head_nxt  = (hit_idx1 >= lim_ext) ? '0 : hit_idx1[SLOT_W-1:0];
    end else if (cmd.do_free) begin
      bit_sel = {{(WORD_BITS-1){1'b0}}, 1'b1} << target_r[OFF_W-1:0];
      wr_en   = 1'b1;
      wr_data = rd_word & ~bit_sel;
      if (count_r != '0) begin
        count_nxt = count_r - COUNT_W'(1);
      end
    end
  end

  // bitmap memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      bitmap_mem[cursor_r] <= wr_data;
    end
    rd_data_r <= bitmap_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAP_WORDS; i++) begin
        word_vld_r[i] <= 1'b0;
      end
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        word_vld_r[cursor_r] <= 1'b1;
      end
      rd_vld_r <= word_vld_r[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      count_r    <= '0;
      wrapped_r  <= 1'b0;
      cursor_r   <= '0;
      res_strobe <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      wrapped_r  <= wrapped_nxt;
      cursor_r   <= cursor_nxt;
      res_strobe <= cmd.report;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= req.mode;
      target_r <= req.slot_to_free;
      ws_r     <= start_idx[OFF_W +: WAW];
      soff_r   <= start_idx[OFF_W-1:0];
    end
  end

  // result beat
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      res.status         <= cmd.res_status;
      res.granted_slot   <= cmd.do_alloc ? hit_idx[SLOT_W-1:0] : '0;
      res.occupied_count <= count_nxt;
    end
  end

endmodule
